// ===== hdl/spherical_uv_mapper_macros.svh =====
// Assertion macros for the spherical UV mapper.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef SPHERICAL_UV_MAPPER_MACROS_SVH
`define SPHERICAL_UV_MAPPER_MACROS_SVH
`ifndef SYNTHESIS
`define SUVM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("spherical_uv_mapper: check failed");
`define SUVM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("spherical_uv_mapper: check failed");
`else
`define SUVM_ASSERT_IMP(lbl, ante, cons)
`define SUVM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/suvm_pkg.sv =====
`default_nettype none
package suvm_pkg;

	// Datapath width of the CORDIC vector; inputs are scaled to a magnitude of 2^39.
	localparam int CW = 44;
	// Angle accumulator width, in units of 2^-32 turn.
	localparam int ACC_W = 34;
	// Width of the texture coordinate ports.
	localparam int UV_W = 17;
	localparam int CORDIC_STEPS = 32;
	localparam int ATAN_W = 30;
	localparam logic [30:0] CORDIC_GAIN_Q30 = 31'd1768195363;
	localparam logic signed [ACC_W-1:0] HALF_TURN = ACC_W'(64'sd2147483648);

	// Arctangent of 2^-i in units of 2^-32 turn.
	localparam logic [ATAN_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331, 30'd21354465, 30'd10679838, 30'd5340245,
		30'd2670163, 30'd1335087, 30'd667544, 30'd333772,
		30'd166886, 30'd83443, 30'd41722, 30'd20861,
		30'd10430, 30'd5215, 30'd2608, 30'd1304,
		30'd652, 30'd326, 30'd163, 30'd81,
		30'd41, 30'd20, 30'd10, 30'd5,
		30'd3, 30'd1, 30'd1, 30'd0
	};

	// One CORDIC vector with its accumulated angle.
	typedef struct packed {
		logic signed [CW-1:0]    x;
		logic signed [CW-1:0]    y;
		logic signed [ACC_W-1:0] acc;
	} suvm_vec_t;

endpackage
`default_nettype wire

// ===== hdl/spherical_uv_mapper.sv =====
// Spherical texture coordinate mapper.
// Input: a transaction is taken at a rising edge where start is high and
// busy is low. busy is always low, so one vertex (pos_x, pos_y, pos_z) can
// be taken in every cycle.
// Output: each result stands on tex_u, tex_v and zero_vector for one cycle
// while done is high; the receiver has no way to hold it off.
// From the accepting edge to the edge that ends the done cycle, a vertex
// passes a half-turn pre-rotation stage, 32 CORDIC cells for the azimuth, a
// multiply stage for the gain match of y, a second pre-rotation stage, 32
// CORDIC cells for the polar angle and an output register.
// Throughput is one vertex per cycle; every cell hands its vector to the
// next one in each cycle.
// u is the azimuth atan2(z, x) plus a half turn over a full turn, and v is
// one minus the polar angle from the y axis over a half turn, both with
// UV_FRAC_BITS fraction bits. The origin raises zero_vector.
// Reset clears the valid bits of the chain, so no result comes out for
// vertices in flight at reset.
`default_nettype none
`include "spherical_uv_mapper_macros.svh"
module spherical_uv_mapper import suvm_pkg::*; #(
	parameter int COORD_BITS   = 16,
	parameter int UV_FRAC_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic signed [COORD_BITS-1:0] pos_x,
	input  wire logic signed [COORD_BITS-1:0] pos_y,
	input  wire logic signed [COORD_BITS-1:0] pos_z,
	output logic                              done,
	output logic [UV_W-1:0]                   tex_u,
	output logic [UV_W-1:0]                   tex_v,
	output logic                              zero_vector
);

	localparam int SCALE_SHIFT = 40 - COORD_BITS;
	localparam int PROD_W = COORD_BITS + 32;
	localparam int SIDE_A = COORD_BITS + 3;
	localparam int SIDE_P = ACC_W + 3;
	localparam int OW = ACC_W + 2;

	// Input scaling and flags.
	logic signed [CW-1:0] px_in, pz_in;
	logic                 in_zero, in_axis, in_ypos, in_fire;

	assign busy = 1'b0;
	assign in_fire = start && !busy;

	always_comb begin
		px_in = CW'(pos_x) <<< SCALE_SHIFT;
		pz_in = CW'(pos_z) <<< SCALE_SHIFT;
		in_axis = (pos_x == '0) && (pos_z == '0);
		in_zero = in_axis && (pos_y == '0);
		in_ypos = !pos_y[COORD_BITS-1] && (pos_y != '0);
	end

	// Azimuth chain.
	logic              az_vld  [CORDIC_STEPS+1];
	suvm_vec_t         az_vec  [CORDIC_STEPS+1];
	logic [SIDE_A-1:0] az_side [CORDIC_STEPS+1];

	suvm_prerot #(.SIDE_W(SIDE_A)) u_az_prerot (
		.clk(clk), .arst_n(arst_n), .vld_i(in_fire), .px_i(px_in), .py_i(pz_in),
		.side_i({in_zero, in_axis, in_ypos, pos_y}),
		.vld_o(az_vld[0]), .vec_o(az_vec[0]), .side_o(az_side[0])
	);

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_az
		suvm_cordic_cell #(.STEP(i), .SIDE_W(SIDE_A)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.vld_i(az_vld[i]), .vec_i(az_vec[i]), .side_i(az_side[i]),
			.vld_o(az_vld[i+1]), .vec_o(az_vec[i+1]), .side_o(az_side[i+1])
		);
	end

	// Gain match: y times the CORDIC gain, registered.
	logic                        mul_vld_s1;
	logic signed [PROD_W-1:0]    prod_s1;
	logic signed [CW-1:0]        rho_s1;
	logic signed [ACC_W-1:0]     azim_s1;
	logic [2:0]                  flags_s1;
	logic signed [COORD_BITS-1:0] y_end;
	logic signed [CW-1:0]        yk;

	assign y_end = az_side[CORDIC_STEPS][COORD_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_vld_s1 <= 1'b0;
		end else begin
			mul_vld_s1 <= az_vld[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(y_end) * $signed({1'b0, CORDIC_GAIN_Q30});
		rho_s1 <= az_vec[CORDIC_STEPS].x;
		azim_s1 <= az_vec[CORDIC_STEPS].acc;
		flags_s1 <= az_side[CORDIC_STEPS][SIDE_A-1:COORD_BITS];
	end

	// Bring the product to the scale of the length.
	if (SCALE_SHIFT >= 30) begin : g_yk_up
		assign yk = CW'(prod_s1) <<< (SCALE_SHIFT - 30);
	end else begin : g_yk_dn
		logic signed [PROD_W-1:0] prod_sh;
		assign prod_sh = prod_s1 >>> (30 - SCALE_SHIFT);
		assign yk = CW'(prod_sh);
	end

	// Polar chain.
	logic              po_vld  [CORDIC_STEPS+1];
	suvm_vec_t         po_vec  [CORDIC_STEPS+1];
	logic [SIDE_P-1:0] po_side [CORDIC_STEPS+1];

	suvm_prerot #(.SIDE_W(SIDE_P)) u_po_prerot (
		.clk(clk), .arst_n(arst_n), .vld_i(mul_vld_s1), .px_i(yk), .py_i(rho_s1),
		.side_i({flags_s1, azim_s1}),
		.vld_o(po_vld[0]), .vec_o(po_vec[0]), .side_o(po_side[0])
	);

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_po
		suvm_cordic_cell #(.STEP(i), .SIDE_W(SIDE_P)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.vld_i(po_vld[i]), .vec_i(po_vec[i]), .side_i(po_side[i]),
			.vld_o(po_vld[i+1]), .vec_o(po_vec[i+1]), .side_o(po_side[i+1])
		);
	end

	// Output mapping with clamping and round half up.
	logic signed [ACC_W-1:0] azim_e, polar_e;
	logic                    e_zero, e_axis, e_ypos;
	logic signed [OW-1:0]    tu, tv;
	logic [OW-1:0]           u_full, v_full;

	always_comb begin
		azim_e = po_side[CORDIC_STEPS][ACC_W-1:0];
		e_ypos = po_side[CORDIC_STEPS][ACC_W];
		e_axis = po_side[CORDIC_STEPS][ACC_W+1];
		e_zero = po_side[CORDIC_STEPS][ACC_W+2];
		polar_e = po_vec[CORDIC_STEPS].acc;
		if (e_axis) begin
			azim_e = '0;
			polar_e = e_ypos ? '0 : HALF_TURN;
		end
		tu = OW'(azim_e) + OW'(HALF_TURN);
		if (tu < 0) begin
			tu = '0;
		end else if (tu > (OW'(HALF_TURN) <<< 1)) begin
			tu = OW'(HALF_TURN) <<< 1;
		end
		if (polar_e < 0) begin
			polar_e = '0;
		end else if (polar_e > HALF_TURN) begin
			polar_e = HALF_TURN;
		end
		tv = OW'(HALF_TURN) - OW'(polar_e);
		u_full = (OW'(tu) + (OW'(1) << (31 - UV_FRAC_BITS))) >> (32 - UV_FRAC_BITS);
		v_full = (OW'(tv) + (OW'(1) << (30 - UV_FRAC_BITS))) >> (31 - UV_FRAC_BITS);
		if (e_zero) begin
			u_full = OW'(1) << (UV_FRAC_BITS - 1);
			v_full = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= po_vld[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		tex_u <= u_full[UV_W-1:0];
		tex_v <= v_full[UV_W-1:0];
		zero_vector <= e_zero;
	end

	// Checks on the output stage and on the gain match stage.
	`SUVM_ASSERT_NXT(a_done_follows, po_vld[CORDIC_STEPS], done)
	`SUVM_ASSERT_NXT(a_no_spurious, !po_vld[CORDIC_STEPS], !done)
	`SUVM_ASSERT_IMP(a_zero_v, done && zero_vector, tex_v == '0)
	`SUVM_ASSERT_NXT(a_chain_mid, az_vld[CORDIC_STEPS], mul_vld_s1)

endmodule
`default_nettype wire

// ===== hdl/suvm_cordic_cell.sv =====
`default_nettype none
module suvm_cordic_cell import suvm_pkg::*; #(
	parameter int STEP   = 0,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              vld_i,
	input  wire suvm_vec_t         vec_i,
	input  wire logic [SIDE_W-1:0] side_i,
	output logic                   vld_o,
	output suvm_vec_t              vec_o,
	output logic [SIDE_W-1:0]      side_o
);

	logic signed [CW-1:0]    x_in, y_in, dx, dy;
	logic signed [ACC_W-1:0] ang;
	suvm_vec_t               nxt;

	// One vectoring micro-rotation driving y toward zero.
	always_comb begin
		x_in = vec_i.x;
		y_in = vec_i.y;
		dx = y_in >>> STEP;
		dy = x_in >>> STEP;
		ang = $signed({{(ACC_W-ATAN_W){1'b0}}, ATAN_TURNS[STEP]});
		if (!y_in[CW-1]) begin
			nxt.x = x_in + dx;
			nxt.y = y_in - dy;
			nxt.acc = vec_i.acc + ang;
		end else begin
			nxt.x = x_in - dx;
			nxt.y = y_in + dy;
			nxt.acc = vec_i.acc - ang;
		end
	end

	// The valid bit is control state and is reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else begin
			vld_o <= vld_i;
		end
	end

	// Payload moves to the neighbor every cycle.
	always_ff @(posedge clk) begin
		vec_o <= nxt;
		side_o <= side_i;
	end

endmodule
`default_nettype wire

// ===== hdl/suvm_prerot.sv =====
`default_nettype none
module suvm_prerot import suvm_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 vld_i,
	input  wire logic signed [CW-1:0] px_i,
	input  wire logic signed [CW-1:0] py_i,
	input  wire logic [SIDE_W-1:0]    side_i,
	output logic                      vld_o,
	output suvm_vec_t                 vec_o,
	output logic [SIDE_W-1:0]         side_o
);

	suvm_vec_t nxt;

	// A vector in the left half plane is turned by a half turn first.
	always_comb begin
		if (px_i[CW-1]) begin
			nxt.x = -px_i;
			nxt.y = -py_i;
			nxt.acc = py_i[CW-1] ? -HALF_TURN : HALF_TURN;
		end else begin
			nxt.x = px_i;
			nxt.y = py_i;
			nxt.acc = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		vec_o <= nxt;
		side_o <= side_i;
	end

endmodule
`default_nettype wire
